FILE: src/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types, constants and microcode for the setpoint tracker
// Holds the control word layout, the program labels and the program itself.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int STEP_W = 5;

    // opcodes carried in the input tuser
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_SP = 2'd0;
    localparam logic [1:0] REG_MAX_SP = 2'd1;
    localparam logic [1:0] REG_DUTY   = 2'd2;
    localparam logic [1:0] REG_INV    = 2'd3;

    // register reset values
    localparam logic [15:0] RST_MIN_SP = 16'd8000;
    localparam logic [15:0] RST_MAX_SP = 16'd30000;
    localparam logic [15:0] RST_DUTY   = 16'd31130;
    localparam logic [15:0] RST_INV    = 16'd4312;

    // tracking constants, millivolts
    localparam logic [15:0] SLOW_FLOOR_MV   = 16'd5000;
    localparam logic [15:0] SLOW_KNEE_MV    = 16'd5001;
    localparam logic [16:0] SLEW_MV         = 17'd500;
    localparam logic [16:0] DRIVE_OFS_MV    = 17'd1000;
    localparam logic [15:0] BUTTON_MV       = 16'd20000;
    localparam logic [16:0] READY_MARGIN_MV = 17'd500;
    localparam logic signed [18:0] DRIVE_MARGIN_MV = 19'sd500;
    localparam logic [33:0] ROUND_Q12       = 34'd2048;

    // program labels
    localparam logic [STEP_W-1:0] ST_WAIT     = 5'd0;
    localparam logic [STEP_W-1:0] ST_DISPATCH = 5'd1;
    localparam logic [STEP_W-1:0] ST_U_PEAK   = 5'd2;
    localparam logic [STEP_W-1:0] ST_U_SLOW   = 5'd3;
    localparam logic [STEP_W-1:0] ST_U_DECAY  = 5'd4;
    localparam logic [STEP_W-1:0] ST_U_MUL    = 5'd5;
    localparam logic [STEP_W-1:0] ST_U_SUM    = 5'd6;
    localparam logic [STEP_W-1:0] ST_U_CLAMP  = 5'd7;
    localparam logic [STEP_W-1:0] ST_START    = 5'd8;
    localparam logic [STEP_W-1:0] ST_STOP     = 5'd9;
    localparam logic [STEP_W-1:0] ST_R_MULA   = 5'd10;
    localparam logic [STEP_W-1:0] ST_R_MD     = 5'd11;
    localparam logic [STEP_W-1:0] ST_R_MULH   = 5'd12;
    localparam logic [STEP_W-1:0] ST_R_HEAD   = 5'd13;
    localparam logic [STEP_W-1:0] ST_R_CHK    = 5'd14;
    localparam logic [STEP_W-1:0] ST_R_DIV    = 5'd15;
    localparam logic [STEP_W-1:0] ST_OUT      = 5'd16;

    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,
        U_PEAK,
        U_SLOW,
        U_DECAY,
        U_MULD,
        U_SUM,
        U_CLAMP,
        U_START,
        U_STOP,
        U_MULA,
        U_MD,
        U_MULH,
        U_HEAD,
        U_CHK,
        U_DIV,
        U_OUT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_GOTO,
        C_WAIT_IN,
        C_OPCODE,
        C_SAT,
        C_CNT_NZ,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop              uop;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    function automatic t_uword f_rom(input logic [STEP_W-1:0] addr);
        t_uword w;
        case (addr)
            ST_WAIT:     w = '{U_LOAD,  C_WAIT_IN,  ST_WAIT};
            ST_DISPATCH: w = '{U_NOP,   C_OPCODE,   ST_U_PEAK};
            ST_U_PEAK:   w = '{U_PEAK,  C_NEXT,     ST_WAIT};
            ST_U_SLOW:   w = '{U_SLOW,  C_NEXT,     ST_WAIT};
            ST_U_DECAY:  w = '{U_DECAY, C_NEXT,     ST_WAIT};
            ST_U_MUL:    w = '{U_MULD,  C_NEXT,     ST_WAIT};
            ST_U_SUM:    w = '{U_SUM,   C_NEXT,     ST_WAIT};
            ST_U_CLAMP:  w = '{U_CLAMP, C_GOTO,     ST_R_MULA};
            ST_START:    w = '{U_START, C_GOTO,     ST_R_MULA};
            ST_STOP:     w = '{U_STOP,  C_GOTO,     ST_R_MULA};
            ST_R_MULA:   w = '{U_MULA,  C_NEXT,     ST_WAIT};
            ST_R_MD:     w = '{U_MD,    C_NEXT,     ST_WAIT};
            ST_R_MULH:   w = '{U_MULH,  C_NEXT,     ST_WAIT};
            ST_R_HEAD:   w = '{U_HEAD,  C_NEXT,     ST_WAIT};
            ST_R_CHK:    w = '{U_CHK,   C_SAT,      ST_OUT};
            ST_R_DIV:    w = '{U_DIV,   C_CNT_NZ,   ST_R_DIV};
            ST_OUT:      w = '{U_OUT,   C_OUT_BUSY, ST_WAIT};
            default:     w = '{U_NOP,   C_GOTO,     ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: src/boost_setpoint_tracker_core.sv
// ----------------------------------------------------------------------------
// boost_setpoint_tracker_core: boost converter setpoint tracker
// Microcoded sequencer over a small datapath that tracks drop, drive and
// slow-start state and reports the commanded voltage and drive limits.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The result beat becomes valid at the output
// step, once the program for its opcode has run: update beats pass the
// tracking steps, start and stop beats their own step, and every beat then
// the result steps. When the utilization saturates, the 16-step divide loop
// is skipped. The restoring divider yields one quotient bit a cycle. The
// result sits in an output register, so the sequencer is back at its wait
// step and takes the next input beat in the cycle after the result is
// loaded, even while that result is still not taken. Input beats are taken
// only at the wait step, so no beat is accepted before the previous one
// has reached the output step. Configuration writes are always accepted
// and are meant for idle periods.
module boost_setpoint_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // requested_drive_mv[15:0], bus_min_mv[31:16], button_pressed[32],
    // bus_now_mv[48:33], query_voltage_mv[64:49], zero pad[71:65]
    input  logic [71:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // boost_enable[0], commanded_mv[16:1], boost_ready[17],
    // max_drive_mv[34:18], utilization_q14[50:35], zero pad[55:51]
    output logic [55:0] m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic [bst_pkg::STEP_W-1:0] r_step;
    logic [bst_pkg::STEP_W-1:0] n_step;
    bst_pkg::t_uword            w_uw;
    logic                       w_in_acc;
    logic                       w_out_free;
    logic                       w_sat;
    logic [3:0]                 r_cnt;

    // captured item
    logic [1:0]  r_opcode;
    logic [15:0] r_req;
    logic [15:0] r_bus_min;
    logic        r_button;
    logic [15:0] r_bus_now;
    logic [15:0] r_query;

    // configuration
    logic [15:0] r_min_sp;
    logic [15:0] r_max_sp;
    logic [15:0] r_duty;
    logic [15:0] r_inv;

    // tracking state
    logic [15:0] r_peak_drop;
    logic [15:0] r_peak_drive;
    logic [15:0] r_slow;
    logic [15:0] r_setpoint;
    logic        r_enabled;

    // datapath scratch
    logic [32:0]        r_prod_u;
    logic signed [33:0] r_prod_s;
    logic [15:0]        r_acc;
    logic signed [16:0] r_md;
    logic signed [18:0] r_head;
    logic               r_sat;
    logic [18:0]        r_rem;
    logic [15:0]        r_quo;

    // output register
    logic        r_out_valid;
    logic [55:0] r_out_data;

    assign w_uw          = bst_pkg::f_rom(r_step);
    assign s_axis_tready = (r_step == bst_pkg::ST_WAIT);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------
    // datapath combinational terms
    // ------------------------------------------------------------------
    logic [15:0]        w_drop;
    logic [16:0]        w_want17;
    logic [15:0]        w_want;
    logic [16:0]        w_hi17;
    logic [15:0]        w_hi;
    logic [16:0]        w_d1k;
    logic [32:0]        w_uprod;
    logic [33:0]        w_rnd;
    logic [22:0]        w_sum;
    logic [15:0]        w_sum_sat;
    logic [15:0]        w_btn;
    logic [15:0]        w_cmin;
    logic [15:0]        w_cmax;
    logic [15:0]        w_mul_a;
    logic signed [16:0] w_x;
    logic signed [16:0] w_duty_s;
    logic signed [33:0] w_sprod;
    logic signed [18:0] w_a;
    logic signed [18:0] w_slow_s;
    logic signed [18:0] w_lim;
    logic signed [16:0] w_md;
    logic               w_head_pos;
    logic               w_over;
    logic               w_nbit;
    logic [18:0]        w_trial;
    logic [18:0]        w_dv;
    logic               w_ready;
    logic [15:0]        w_util;

    // present drop of the bus below the setpoint
    assign w_drop   = (r_setpoint > r_bus_min) ? (r_setpoint - r_bus_min) : 16'd0;

    // slow-start target and upper slew bound, both saturating
    assign w_want17 = {1'b0, r_req} + bst_pkg::DRIVE_OFS_MV;
    assign w_want   = w_want17[16] ? 16'hFFFF : w_want17[15:0];
    assign w_hi17   = {1'b0, r_slow} + bst_pkg::SLEW_MV;
    assign w_hi     = w_hi17[16] ? 16'hFFFF : w_hi17[15:0];

    // (drive + 1000) * 1/duty in q12, round half up, add drop, saturate
    assign w_d1k     = {1'b0, r_peak_drive} + bst_pkg::DRIVE_OFS_MV;
    assign w_uprod   = {16'd0, w_d1k} * {17'd0, r_inv};
    assign w_rnd     = {1'b0, r_prod_u} + bst_pkg::ROUND_Q12;
    assign w_sum     = {1'b0, w_rnd[33:12]} + {7'd0, r_peak_drop};
    assign w_sum_sat = (w_sum[22:16] != 7'd0) ? 16'hFFFF : w_sum[15:0];

    // button floor, then min, then max so max wins on crossed limits
    assign w_btn  = (r_button && (r_acc < bst_pkg::BUTTON_MV)) ? bst_pkg::BUTTON_MV : r_acc;
    assign w_cmin = (w_btn < r_min_sp) ? r_min_sp : w_btn;
    assign w_cmax = (w_cmin > r_max_sp) ? r_max_sp : w_cmin;

    // shared signed multiplier: (setpoint or max) minus drop, times duty
    assign w_mul_a  = (w_uw.uop == bst_pkg::U_MULH) ? r_max_sp : r_setpoint;
    assign w_x      = $signed({1'b0, w_mul_a}) - $signed({1'b0, r_peak_drop});
    assign w_duty_s = $signed({1'b0, r_duty});
    assign w_sprod  = 34'(w_x) * 34'(w_duty_s);

    // floor shift by 15 is the top bits of the signed product, less margin
    assign w_a      = $signed(r_prod_s[33:15]) - bst_pkg::DRIVE_MARGIN_MV;
    assign w_slow_s = $signed({3'b000, r_slow});
    assign w_lim    = (w_a < w_slow_s) ? w_a : w_slow_s;

    always_comb begin
        if (w_lim < -19'sd65536) begin
            w_md = -17'sd65536;
        end else if (w_lim > 19'sd65535) begin
            w_md = 17'sd65535;
        end else begin
            w_md = w_lim[16:0];
        end
    end

    // quotient saturates when headroom is not positive or query >= 4 * headroom
    assign w_head_pos = !r_head[18] && (r_head != 19'sd0);
    assign w_over     = ({3'b000, r_query} >= {r_head[16:0], 2'b00});
    assign w_sat      = !w_head_pos || w_over;

    // restoring divide of query << 14, upper part preloaded, low bits fed here
    always_comb begin
        case (r_cnt)
            4'd15:   w_nbit = r_query[1];
            4'd14:   w_nbit = r_query[0];
            default: w_nbit = 1'b0;
        endcase
    end
    assign w_trial = {r_rem[17:0], w_nbit};
    assign w_dv    = r_head;

    assign w_ready = (({1'b0, r_bus_now} + bst_pkg::READY_MARGIN_MV) >= {1'b0, r_setpoint});
    assign w_util  = r_sat ? 16'hFFFF : r_quo;

    // ------------------------------------------------------------------
    // next step
    // ------------------------------------------------------------------
    always_comb begin
        case (w_uw.cond)
            bst_pkg::C_NEXT:     n_step = r_step + 5'd1;
            bst_pkg::C_GOTO:     n_step = w_uw.target;
            bst_pkg::C_WAIT_IN:  n_step = w_in_acc ? (r_step + 5'd1) : r_step;
            bst_pkg::C_OPCODE: begin
                case (r_opcode)
                    bst_pkg::OP_UPDATE: n_step = w_uw.target;
                    bst_pkg::OP_START:  n_step = bst_pkg::ST_START;
                    bst_pkg::OP_STOP:   n_step = bst_pkg::ST_STOP;
                    default:            n_step = bst_pkg::ST_R_MULA;
                endcase
            end
            bst_pkg::C_SAT:      n_step = w_sat ? w_uw.target : (r_step + 5'd1);
            bst_pkg::C_CNT_NZ:   n_step = (r_cnt != 4'd0) ? w_uw.target : (r_step + 5'd1);
            bst_pkg::C_OUT_BUSY: n_step = w_out_free ? w_uw.target : r_step;
            default:             n_step = bst_pkg::ST_WAIT;
        endcase
    end

    // ------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= bst_pkg::ST_WAIT;
            r_out_valid  <= 1'b0;
            r_min_sp     <= bst_pkg::RST_MIN_SP;
            r_max_sp     <= bst_pkg::RST_MAX_SP;
            r_duty       <= bst_pkg::RST_DUTY;
            r_inv        <= bst_pkg::RST_INV;
            r_peak_drop  <= 16'd0;
            r_peak_drive <= 16'd0;
            r_slow       <= bst_pkg::SLOW_FLOOR_MV;
            r_setpoint   <= bst_pkg::RST_MIN_SP;
            r_enabled    <= 1'b0;
        end else begin
            r_step <= n_step;

            // result register: loaded at the output step, drained by the sink
            if (w_uw.uop == bst_pkg::U_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bst_pkg::REG_MIN_SP: r_min_sp <= i_cfg_data;
                    bst_pkg::REG_MAX_SP: r_max_sp <= i_cfg_data;
                    bst_pkg::REG_DUTY:   r_duty   <= i_cfg_data;
                    bst_pkg::REG_INV:    r_inv    <= i_cfg_data;
                    default:             r_inv    <= r_inv;
                endcase
            end

            case (w_uw.uop)
                bst_pkg::U_PEAK: begin
                    if (w_drop > r_peak_drop) begin
                        r_peak_drop <= w_drop;
                    end
                    if (r_req > r_peak_drive) begin
                        r_peak_drive <= r_req;
                    end
                end
                bst_pkg::U_SLOW: begin
                    if (w_want < r_slow) begin
                        r_slow <= r_slow;
                    end else if (w_want > w_hi) begin
                        r_slow <= w_hi;
                    end else begin
                        r_slow <= w_want;
                    end
                end
                bst_pkg::U_DECAY: begin
                    r_peak_drop  <= (r_peak_drop != 16'd0) ? (r_peak_drop - 16'd1) : 16'd0;
                    r_peak_drive <= (r_peak_drive != 16'd0) ? (r_peak_drive - 16'd1) : 16'd0;
                    r_slow       <= (r_slow > bst_pkg::SLOW_KNEE_MV) ? (r_slow - 16'd1)
                                                                     : bst_pkg::SLOW_FLOOR_MV;
                end
                bst_pkg::U_CLAMP: begin
                    r_setpoint <= w_cmax;
                end
                bst_pkg::U_START: begin
                    r_peak_drop  <= 16'd0;
                    r_peak_drive <= 16'd0;
                    r_slow       <= bst_pkg::SLOW_FLOOR_MV;
                    r_setpoint   <= r_min_sp;
                    r_enabled    <= 1'b1;
                end
                bst_pkg::U_STOP: begin
                    r_enabled <= 1'b0;
                end
                default: begin
                    r_enabled <= r_enabled;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (w_uw.uop)
            bst_pkg::U_LOAD: begin
                if (w_in_acc) begin
                    r_opcode  <= s_axis_tuser;
                    r_req     <= s_axis_tdata[15:0];
                    r_bus_min <= s_axis_tdata[31:16];
                    r_button  <= s_axis_tdata[32];
                    r_bus_now <= s_axis_tdata[48:33];
                    r_query   <= s_axis_tdata[64:49];
                end
            end
            bst_pkg::U_MULD: begin
                r_prod_u <= w_uprod;
            end
            bst_pkg::U_SUM: begin
                r_acc <= w_sum_sat;
            end
            bst_pkg::U_MULA, bst_pkg::U_MULH: begin
                r_prod_s <= w_sprod;
            end
            bst_pkg::U_MD: begin
                r_md <= w_md;
            end
            bst_pkg::U_HEAD: begin
                r_head <= w_a;
                r_rem  <= {5'd0, r_query[15:2]};
                r_quo  <= 16'd0;
                r_cnt  <= 4'd15;
            end
            bst_pkg::U_CHK: begin
                r_sat <= w_sat;
            end
            bst_pkg::U_DIV: begin
                if (w_trial >= w_dv) begin
                    r_rem <= w_trial - w_dv;
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt - 4'd1;
            end
            bst_pkg::U_OUT: begin
                if (w_out_free) begin
                    r_out_data <= {5'd0, w_util, r_md, w_ready,
                                   (r_enabled ? r_setpoint : 16'd0), r_enabled};
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_step == bst_pkg::ST_DISPATCH))
        else $error("accepted beat did not reach dispatch");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_step) == bst_pkg::ST_OUT))
        else $error("result raised outside the output step");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == bst_pkg::ST_R_DIV && r_cnt == 4'd0) |=> (r_step == bst_pkg::ST_OUT))
        else $error("divide loop did not end after its last bit");

    a_sat_skips_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == bst_pkg::ST_R_CHK && w_sat) |=> (r_step == bst_pkg::ST_OUT && r_sat))
        else $error("saturated utilization entered the divide loop");

endmodule
